// File: sv/vn_pkg.sv
// Package for the 3D vector normalizer: item structs, defaults and fixed widths.
// No dependencies; vn_div_lane and the top level import it.
package vn_pkg;

  // Defaults for the top-level parameters
  localparam int COMPONENT_BITS_DEF = 32;
  localparam int FRACTION_BITS_DEF  = 16;

  // Width of every data field on the ports
  localparam int FIELD_W = 32;

  // Unit components are Q1.30; a quotient of a magnitude over the length is at
  // most 1.0, so it needs one integer bit and thirty fraction bits
  localparam int UNIT_FRAC = 30;
  localparam int QUOT_BITS = UNIT_FRAC + 1;

  // Number of lanes: x, y and z
  localparam int LANES = 3;

  typedef struct packed {
    logic                      kind;
    logic signed [FIELD_W-1:0] x_in;
    logic signed [FIELD_W-1:0] y_in;
    logic signed [FIELD_W-1:0] z_in;
    logic signed [FIELD_W-1:0] w_in;
  } vn_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_unit;
    logic signed [FIELD_W-1:0] y_unit;
    logic signed [FIELD_W-1:0] z_unit;
    logic signed [FIELD_W-1:0] w_out;
    logic        [FIELD_W-1:0] length;
    logic                      zero_length;
  } vn_out_t;

endpackage

// File: sv/vn_delay.sv
// Fixed-length delay line with a reset valid lane and an unreset data lane.
// Depends on nothing; used by the top level to keep side data in step.
module vn_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [W-1:0] d_i,
  output logic         vld_o,
  output logic [W-1:0] q_o
);

  logic [D-1:0] vld_r;
  logic [W-1:0] dat_r [D];

  // Advance the valid lane, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= D'({vld_r, vld_i});
    end
  end

  // Advance the data lane
  always_ff @(posedge clk) begin
    dat_r[0] <= d_i;
    for (int i = 1; i < D; i++) begin
      dat_r[i] <= dat_r[i-1];
    end
  end

  assign vld_o = vld_r[D-1];
  assign q_o   = dat_r[D-1];

endmodule

// File: sv/vn_sqrt.sv
// Pipelined floor square root, one result bit (one digit pair) per stage.
// Depends on nothing; the top level feeds it the sum of squares.
module vn_sqrt #(
  parameter int CB = 32
) (
  input  logic              clk,
  input  logic [2*CB+1:0]   rad_i,
  output logic [CB-1:0]     root_o
);

  localparam int P   = CB + 1;
  localparam int RW  = 2 * P;
  localparam int SW  = P;
  localparam int RMW = SW + 3;

  logic [RW-1:0]  rad_r  [P];
  logic [RMW-1:0] rem_r  [P];
  logic [SW-1:0]  root_r [P];

  for (genvar i = 0; i < P; i++) begin : g_stage
    logic [RW-1:0]  rad_in;
    logic [RMW-1:0] rem_in;
    logic [SW-1:0]  root_in;
    logic [RMW-1:0] sh;
    logic [RMW-1:0] trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // Bring down the next digit pair and try root*4+1
    assign sh    = {rem_in[RMW-3:0], rad_in[RW-1 -: 2]};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      rad_r[i]  <= rad_in << 2;
      rem_r[i]  <= ge ? (sh - trial) : sh;
      root_r[i] <= {root_in[SW-2:0], ge};
    end
  end

  // The length always fits CB bits
  assign root_o = root_r[P-1][CB-1:0];

endmodule

// File: sv/vn_div_lane.sv
// One divider lane: magnitude * 2^30 / length, one quotient bit per stage.
// Depends on vn_pkg for the quotient width.
module vn_div_lane #(
  parameter int CB = 32
) (
  input  logic                      clk,
  input  logic [CB-1:0]             mag_i,
  input  logic [CB-1:0]             len_i,
  output logic [vn_pkg::QUOT_BITS-1:0] q_o
);

  import vn_pkg::*;

  localparam int QB = QUOT_BITS;

  logic [CB-1:0] rem_r [QB];
  logic [CB-1:0] len_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [CB:0]   sh;
    logic [CB-1:0] len_in;
    logic [QB-1:0] q_in;
    logic          ge;

    // The magnitude never exceeds the length, so the first step needs no shift
    if (k == 0) begin : g_first
      assign sh     = {1'b0, mag_i};
      assign len_in = len_i;
      assign q_in   = '0;
    end else begin : g_next
      assign sh     = {rem_r[k-1], 1'b0};
      assign len_in = len_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign ge = (sh >= {1'b0, len_in});

    // Subtract where it fits and shift in the quotient bit
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? CB'(sh - {1'b0, len_in}) : sh[CB-1:0];
      len_r[k] <= len_in;
      q_r[k]   <= {q_in[QB-2:0], ge};
    end
  end

  assign q_o = q_r[QB-1];

endmodule

// File: sv/vector3_normalize_top.sv
// Top level of the 3D vector normalizer: squares, square root, three divider
// lanes and the merging output register. Depends on vn_pkg, vn_delay, vn_sqrt
// and vn_div_lane.
//
// Use: drive in_item and raise start; the item is taken at the clock edge where
// start is high and busy is low. busy is always low, so an item may be given
// every cycle and one result leaves every cycle.
// Each result shows on out_item for one cycle with out_valid high, once its item
// has passed through three front stages, the square root pipeline, one stage per
// result bit (COMPONENT_BITS + 1 stages), the divider lanes, one stage per
// quotient bit (31 stages), and the output register.
// Results leave in the order their items came in. The receiver cannot stall
// the block, so a result not taken in its cycle is gone.
// Reset clears the valid pipeline only; no result appears until new items
// arrive. The block holds no state between items.
module vector3_normalize_top #(
  parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = vn_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  vn_pkg::vn_in_t  in_item,
  output logic            out_valid,
  output vn_pkg::vn_out_t out_item
);

  import vn_pkg::*;

  localparam int CB      = COMPONENT_BITS;
  localparam int RB      = (CB > FIELD_W) ? CB : FIELD_W;
  localparam int P       = CB + 1;
  localparam int SUMW    = 2 * CB + 2;
  localparam int SIDE1_W = 1 + FIELD_W + LANES + LANES * CB;
  localparam int SIDE2_W = 1 + FIELD_W + LANES + CB + 1;
  localparam int LAT     = P + 35;
  localparam logic [FIELD_W-1:0] W_ONE = FIELD_W'(1) << FRACTION_BITS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Front stage: take magnitudes and signs
  logic [FIELD_W-1:0] comp   [LANES];
  logic [CB-1:0]      mag1_r [LANES];
  logic [LANES-1:0]   neg1_r;
  logic               kind1_r;
  logic [FIELD_W-1:0] w1_r;
  logic               v1_r;

  assign comp[0] = in_item.x_in;
  assign comp[1] = in_item.y_in;
  assign comp[2] = in_item.z_in;

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      logic [CB-1:0] raw;
      raw = CB'(RB'(comp[k]));
      neg1_r[k] <= raw[CB-1];
      mag1_r[k] <= raw[CB-1] ? (~raw + CB'(1)) : raw;
    end
    kind1_r <= in_item.kind;
    w1_r    <= in_item.w_in;
  end

  // Square each lane
  logic [2*CB-1:0]    sq2_r  [LANES];
  logic [CB-1:0]      mag2_r [LANES];
  logic [LANES-1:0]   neg2_r;
  logic               kind2_r;
  logic [FIELD_W-1:0] w2_r;
  logic               v2_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      sq2_r[k]  <= mag1_r[k] * mag1_r[k];
      mag2_r[k] <= mag1_r[k];
    end
    neg2_r  <= neg1_r;
    kind2_r <= kind1_r;
    w2_r    <= w1_r;
  end

  // Add the squares exactly
  logic [SUMW-1:0]    sum3_r;
  logic [SIDE1_W-1:0] side3_r;
  logic               v3_r;

  always_ff @(posedge clk) begin
    sum3_r  <= SUMW'(sq2_r[0]) + SUMW'(sq2_r[1]) + SUMW'(sq2_r[2]);
    side3_r <= {kind2_r, w2_r, neg2_r, mag2_r[0], mag2_r[1], mag2_r[2]};
  end

  // Hold the valid chain of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Square root, with the side data kept in step
  logic [CB-1:0]      len_d;
  logic [SIDE1_W-1:0] side_d;
  logic               vd;

  vn_sqrt #(.CB(CB)) u_sqrt (
    .clk   (clk),
    .rad_i (sum3_r),
    .root_o(len_d)
  );

  vn_delay #(.W(SIDE1_W), .D(P)) u_dly_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .vld_i(v3_r),
    .d_i  (side3_r),
    .vld_o(vd),
    .q_o  (side_d)
  );

  // Divider lanes
  logic [CB-1:0]        mag_d [LANES];
  logic [LANES-1:0]     neg_d;
  logic                 kind_d;
  logic [FIELD_W-1:0]   w_d;
  logic [QUOT_BITS-1:0] q_e [LANES];

  assign {kind_d, w_d, neg_d, mag_d[0], mag_d[1], mag_d[2]} = side_d;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    vn_div_lane #(.CB(CB)) u_lane (
      .clk  (clk),
      .mag_i(mag_d[k]),
      .len_i(len_d),
      .q_o  (q_e[k])
    );
  end

  logic [SIDE2_W-1:0] side_e;
  logic               ve;
  logic               kind_e;
  logic [FIELD_W-1:0] w_e;
  logic [LANES-1:0]   neg_e;
  logic [CB-1:0]      len_e;
  logic               zero_e;

  vn_delay #(.W(SIDE2_W), .D(QUOT_BITS)) u_dly_div (
    .clk  (clk),
    .rst_n(rst_n),
    .vld_i(vd),
    .d_i  ({kind_d, w_d, neg_d, len_d, (len_d == '0)}),
    .vld_o(ve),
    .q_o  (side_e)
  );

  assign {kind_e, w_e, neg_e, len_e, zero_e} = side_e;

  // Merge the lanes into the result item
  logic [FIELD_W-1:0] unit_e [LANES];
  vn_out_t            out_r;
  logic               out_valid_r;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [FIELD_W-1:0] qx;
      qx = FIELD_W'(q_e[k]);
      if (zero_e) begin
        unit_e[k] = '0;
      end else begin
        unit_e[k] = neg_e[k] ? (~qx + FIELD_W'(1)) : qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.x_unit      <= unit_e[0];
    out_r.y_unit      <= unit_e[1];
    out_r.z_unit      <= unit_e[2];
    out_r.w_out       <= kind_e ? W_ONE : w_e;
    out_r.length      <= FIELD_W'(RB'(len_e));
    out_r.zero_length <= zero_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ve;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("item did not leave after the pipeline latency");

  a_zero_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.zero_length == (out_item.length == '0)))
    else $error("zero flag disagrees with length");

  a_zero_units : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_length |->
      (out_item.x_unit == '0) && (out_item.y_unit == '0) && (out_item.z_unit == '0))
    else $error("units not cleared for zero length");

  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.x_unit <= 32'sd1073741824) &&
                  (out_item.x_unit >= -32'sd1073741824))
    else $error("x unit beyond one");

endmodule
